[design/sha1h_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types, constants and helpers for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1h_pkg;

    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
    localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_B1   = 7'd20;
    localparam logic [6:0] ROUND_B2   = 7'd40;
    localparam logic [6:0] ROUND_B3   = 7'd60;
    localparam logic [5:0] POS_LEN    = 6'd56;
    localparam logic [5:0] POS_END    = 6'd63;

    // datapath commands
    typedef struct packed {
        logic load_byte;  // pack data byte at current position, bump count
        logic pad;        // pack 0x80 at current position
        logic put_len;    // write bit length into words 14 and 15
        logic start;      // load working variables from chaining words
        logic round;      // one compression round
        logic finish;     // add into chaining words, clear block
        logic emit;       // capture digest, re-init chaining words and count
    } t_cmd;

    // datapath status
    typedef struct packed {
        logic pos_end;    // current position is the last byte of a block
        logic pos_wide;   // 0x80 would leave no room for the length
        logic round_last;
    } t_sts;

    function automatic logic [31:0] rotl1(input logic [31:0] v);
        rotl1 = {v[30:0], v[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] v);
        rotl5 = {v[26:0], v[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] v);
        rotl30 = {v[1:0], v[31:2]};
    endfunction

endpackage
`default_nettype wire

[design/sha1_byte_stream_hasher.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream: one byte per word, digest out as five words.
// ----------------------------------------------------------------------------
// A byte is taken while the block is idle. The 64th byte of a block starts
// compression, which runs one round per cycle (load, 80 rounds, add) with
// input stalled. An item with last set adds a pad step, a length step and one
// compression, or two when the 0x80 byte lands at block position 56 or later,
// then hands the digest to a one-deep output register. That register holds
// the result while the next message is already being taken in; the block only
// waits in the digest handoff when a previous digest is still unclaimed. An
// item with neither a byte nor last is taken and ignored.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher
    import sha1h_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_last,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [31:0] o_digest_word0,
    output      logic [31:0] o_digest_word1,
    output      logic [31:0] o_digest_word2,
    output      logic [31:0] o_digest_word3,
    output      logic [31:0] o_digest_word4
);

    t_cmd cmd;
    t_sts sts;

    sha1h_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    sha1h_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_data_byte    (i_data_byte),
        .o_sts          (sts),
        .o_digest_word0 (o_digest_word0),
        .o_digest_word1 (o_digest_word1),
        .o_digest_word2 (o_digest_word2),
        .o_digest_word3 (o_digest_word3),
        .o_digest_word4 (o_digest_word4)
    );

endmodule
`default_nettype wire

[design/sha1h_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_dp
// Block buffer, message schedule, round unit, chaining words and digest.
// ----------------------------------------------------------------------------
module sha1h_dp
    import sha1h_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [7:0]  i_data_byte,
    output      t_sts        o_sts,
    output      logic [31:0] o_digest_word0,
    output      logic [31:0] o_digest_word1,
    output      logic [31:0] o_digest_word2,
    output      logic [31:0] o_digest_word3,
    output      logic [31:0] o_digest_word4
);

    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_v [5];
    logic [31:0] r_dig [5];
    logic [63:0] r_cnt;
    logic [6:0]  r_round;

    logic [5:0]  pos;
    logic [3:0]  widx;
    logic [4:0]  wsh;
    logic [7:0]  put_val;
    logic [31:0] put_word;
    logic [63:0] bits;
    logic [31:0] w_new;
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;

    assign pos      = r_cnt[5:0];
    assign widx     = pos[5:2];
    assign wsh      = {~pos[1:0], 3'b000};
    assign put_val  = i_cmd.pad ? PAD_BYTE : i_data_byte;
    assign put_word = {24'd0, put_val} << wsh;
    assign bits     = {r_cnt[60:0], 3'b000};
    assign w_new    = rotl1(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]);

    always_comb begin
        if (r_round < ROUND_B1) begin
            f = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            k = K_R0;
        end else if (r_round < ROUND_B2) begin
            f = r_v[1] ^ r_v[2] ^ r_v[3];
            k = K_R1;
        end else if (r_round < ROUND_B3) begin
            f = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            k = K_R2;
        end else begin
            f = r_v[1] ^ r_v[2] ^ r_v[3];
            k = K_R3;
        end
    end

    assign t = rotl5(r_v[0]) + f + r_v[4] + k + r_w[0];

    assign o_sts.pos_end    = (pos == POS_END);
    assign o_sts.pos_wide   = (pos >= POS_LEN);
    assign o_sts.round_last = (r_round == ROUND_LAST);

    // block buffer; during compression a 16-word schedule window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            for (int i = 0; i < 16; i++) r_w[i] <= '0;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end else if (i_cmd.put_len) begin
            r_w[14] <= bits[63:32];
            r_w[15] <= bits[31:0];
        end else if (i_cmd.load_byte || i_cmd.pad) begin
            r_w[widx] <= r_w[widx] | put_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_cnt <= '0;
        end else if (i_cmd.load_byte) begin
            r_cnt <= r_cnt + 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_h[0] <= H_INIT0;
            r_h[1] <= H_INIT1;
            r_h[2] <= H_INIT2;
            r_h[3] <= H_INIT3;
            r_h[4] <= H_INIT4;
        end else if (i_cmd.finish) begin
            for (int i = 0; i < 5; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start) begin
            r_round <= '0;
        end else if (i_cmd.round) begin
            r_round <= r_round + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int i = 0; i < 5; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round) begin
            r_v[0] <= t;
            r_v[1] <= r_v[0];
            r_v[2] <= rotl30(r_v[1]);
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int i = 0; i < 5; i++) r_dig[i] <= r_h[i];
        end
    end

    assign o_digest_word0 = r_dig[0];
    assign o_digest_word1 = r_dig[1];
    assign o_digest_word2 = r_dig[2];
    assign o_digest_word3 = r_dig[3];
    assign o_digest_word4 = r_dig[4];

    a_start_clears_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (r_round == '0))
        else $error("round counter not cleared on start");

    a_finish_clears_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_w[0] == '0 && r_w[15] == '0))
        else $error("block buffer not cleared after compression");

    a_emit_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_cnt == '0 && r_h[0] == H_INIT0))
        else $error("hash state not re-initialized after digest");

endmodule
`default_nettype wire

[design/sha1h_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_ctrl
// Sequencer: byte intake, padding, compression rounds and digest handoff.
// ----------------------------------------------------------------------------
module sha1h_ctrl
    import sha1h_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output      logic o_stall,
    input  wire logic i_byte_valid,
    input  wire logic i_last,
    output      logic o_valid,
    input  wire logic i_stall,
    input  wire t_sts i_sts,
    output      t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_LEN   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ret, n_ret;
    logic       r_out_valid, n_out_valid;
    logic       acc;
    logic       slot_free;

    assign acc       = i_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_byte_valid) begin
                        o_cmd.load_byte = 1'b1;
                        if (i_sts.pos_end) begin
                            n_state = S_START;
                            n_ret   = i_last ? S_PAD : S_IDLE;
                        end else if (i_last) begin
                            n_state = S_PAD;
                        end
                    end else if (i_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_sts.round_last) n_state = S_FINAL;
            end
            S_FINAL: begin
                o_cmd.finish = 1'b1;
                n_state      = r_ret;
            end
            S_PAD: begin
                o_cmd.pad = 1'b1;
                if (i_sts.pos_wide) begin
                    n_state = S_START;
                    n_ret   = S_LEN;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.put_len = 1'b1;
                n_state       = S_START;
                n_ret         = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
        end
    end

    a_round_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && i_sts.round_last) |=> (r_state == S_FINAL))
        else $error("compression did not finish after last round");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("digest presented outside emit");

    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_byte_valid && i_sts.pos_end) |=> (r_state == S_START))
        else $error("full block not compressed");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> slot_free)
        else $error("digest overwritten while waiting");

endmodule
`default_nettype wire

[tb/sha1_byte_stream_hasher_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_test
// Self-checking bench for the SHA-1 byte stream hasher. Messages of random
// and block-boundary lengths go in a byte per word. A bench-side SHA-1
// model predicts each digest, and every digest that comes out is compared
// word by word with the oldest prediction. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_test;

    typedef logic [4:0][31:0] digest_t;

    localparam digest_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};
    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    localparam int ITEM_TARGET   = 1350;
    localparam int MAX_IDLE      = 14;
    localparam int LONG_HOLD     = 900;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_REPORTS   = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_byte_valid;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word0;
    logic [31:0] o_digest_word1;
    logic [31:0] o_digest_word2;
    logic [31:0] o_digest_word3;
    logic [31:0] o_digest_word4;

    sha1_byte_stream_hasher dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_valid   (i_byte_valid),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word0 (o_digest_word0),
        .o_digest_word1 (o_digest_word1),
        .o_digest_word2 (o_digest_word2),
        .o_digest_word3 (o_digest_word3),
        .o_digest_word4 (o_digest_word4)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // bench-side hasher state
    digest_t           chain_h;
    logic [15:0][31:0] block_w;
    logic [63:0]       msg_len;

    digest_t     expected_digests[$];
    int          items_sent = 0;
    int          mismatch_count = 0;
    bit          send_idle_on = 1'b1;
    bit          recv_idle_on = 1'b1;
    int unsigned hold_off_cycles = 0;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
        rol32 = (v << s) | (v >> (32 - s));
    endfunction

    function automatic void hasher_init();
        chain_h = SHA1_IV;
        block_w = '0;
        msg_len = '0;
    endfunction

    function automatic void pack_byte(input logic [5:0] pos, input logic [7:0] b);
        block_w[pos[5:2]][31 - 8 * pos[1:0] -: 8] = b;
    endfunction

    function automatic void compress_block();
        logic [31:0] a, b, c, d, e, f, k, t;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16)
                block_w[r & 15] = rol32(block_w[(r + 13) & 15] ^ block_w[(r + 8) & 15]
                                        ^ block_w[(r + 2) & 15] ^ block_w[r & 15], 1);
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_00_19;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_20_39;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_40_59;
            end else begin
                f = b ^ c ^ d;
                k = K_60_79;
            end
            t = rol32(a, 5) + f + e + k + block_w[r & 15];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
        block_w = '0;
    endfunction

    function automatic void hasher_take(input logic [7:0] data, input logic has_byte,
                                        input logic is_last);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        if (has_byte) begin
            pos = msg_len[5:0];
            pack_byte(pos, data);
            msg_len = msg_len + 64'd1;
            if (pos == 6'd63)
                compress_block();
        end
        if (!is_last)
            return;
        pos = msg_len[5:0];
        pack_byte(pos, PAD_MARK);
        // no room left for the length: it goes in an extra block
        if (pos >= 6'd56)
            compress_block();
        bit_len = msg_len << 3;
        block_w[14] = bit_len[63:32];
        block_w[15] = bit_len[31:0];
        compress_block();
        expected_digests.push_back(chain_h);
        hasher_init();
    endfunction

    function automatic void flag_error(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR %0t: %s", $realtime, what);
    endfunction

    function automatic int edge_length(input int idx);
        case (idx)
            0: edge_length = 55;
            1: edge_length = 56;
            2: edge_length = 57;
            3: edge_length = 63;
            4: edge_length = 64;
            5: edge_length = 65;
            6: edge_length = 119;
            7: edge_length = 120;
            8: edge_length = 127;
            default: edge_length = 128;
        endcase
    endfunction

    // digest checker
    always @(posedge i_clk) begin : digest_check
        digest_t got;
        digest_t want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            got[0] = o_digest_word0;
            got[1] = o_digest_word1;
            got[2] = o_digest_word2;
            got[3] = o_digest_word3;
            got[4] = o_digest_word4;
            if (expected_digests.size() == 0) begin
                flag_error($sformatf("digest %h with none pending", got));
            end else begin
                want = expected_digests.pop_front();
                for (int i = 0; i < 5; i++)
                    if (got[i] !== want[i])
                        flag_error($sformatf("digest_word%0d expected %h got %h",
                                             i, want[i], got[i]));
            end
        end
    end

    // digest taker: random stall before each digest, long hold-off on request
    initial begin : digest_taker
        int unsigned n;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = recv_idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
            if (n != 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1 || i_stall !== 1'b0) begin
                if (hold_off_cycles != 0) begin
                    n = hold_off_cycles;
                    hold_off_cycles = 0;
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
                @(posedge i_clk);
            end
        end
    end

    task automatic send_word(input logic [7:0] data, input logic has_byte,
                             input logic is_last);
        int unsigned gap;
        gap = send_idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= data;
        i_byte_valid <= has_byte;
        i_last       <= is_last;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        hasher_take(data, has_byte, is_last);
        if (has_byte || is_last)
            items_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_digests.size() != 0);
    endtask

    task automatic test_directed();
        send_word(8'hFF, 1'b0, 1'b1);           // empty message
        send_word(8'hA5, 1'b0, 1'b0);           // ignored word
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);           // byte and last together
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h7F, 1'b1, 1'b0);
        send_word(8'h55, 1'b1, 1'b0);
        send_word(8'hAA, 1'b0, 1'b1);           // last without a byte
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        wait_drained();
    endtask

    // receiver holds off long enough for the block to back up into its input
    task automatic test_output_backpressure();
        int len;
        send_idle_on = 1'b0;
        hold_off_cycles = LONG_HOLD;
        for (int m = 0; m < 6; m++) begin
            len = $urandom_range(4, 1);
            for (int i = 0; i < len; i++)
                send_word(8'($urandom_range(255, 0)), 1'b1, i == len - 1);
        end
        wait_drained();
        send_idle_on = 1'b1;
    endtask

    task automatic test_random_messages();
        int pick;
        int len;
        bit tail_alone;
        while (items_sent < ITEM_TARGET) begin
            send_idle_on = ($urandom_range(4, 0) != 0);
            recv_idle_on = ($urandom_range(4, 0) != 0);
            pick = $urandom_range(99, 0);
            if (pick < 40)
                len = $urandom_range(8, 0);
            else if (pick < 75)
                len = edge_length($urandom_range(9, 0));
            else
                len = $urandom_range(70, 9);
            tail_alone = (len == 0) || ($urandom_range(1, 0) == 1);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(19, 0) == 0)
                    send_word(8'($urandom_range(255, 0)), 1'b0, 1'b0);
                send_word(8'($urandom_range(255, 0)), 1'b1, !tail_alone && i == len - 1);
            end
            if (tail_alone)
                send_word(8'($urandom_range(255, 0)), 1'b0, 1'b1);
            // now and then the sender pauses until every digest is back
            if ($urandom_range(9, 0) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        #(64'd20_000_000);
        $display("sha1_byte_stream_hasher regression: fail");
        $finish;
    end

    initial begin
        hasher_init();
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data_byte  <= 8'h00;
        i_byte_valid <= 1'b0;
        i_last       <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_output_backpressure();
        test_random_messages();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("sha1_byte_stream_hasher regression: pass");
        else
            $display("sha1_byte_stream_hasher regression: fail");
        $finish;
    end

endmodule
